### design/rgbmf5_pkg.sv
// shared types, constants and the pruned sorting network of the rgb 5x5 median filter
package rgbmf5_pkg;

  localparam int MAX_SRC_WIDTH_DEF = 2048;
  localparam int WIN_DIM           = 5;
  localparam int WIN_SIZE          = 25;
  localparam int NET_SIZE          = 32;
  localparam int MEDIAN_RANK       = 12;
  localparam int NUM_LAYERS        = 15;
  localparam int LAYERS_PER_STAGE  = 3;
  localparam int NUM_SORT_STAGES   = (NUM_LAYERS + LAYERS_PER_STAGE - 1) / LAYERS_PER_STAGE;

  localparam int OUT_WIDTH_W  = 11;
  localparam int OUT_HEIGHT_W = 14;
  localparam int SRC_WIDTH_W  = 12;
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_INDEX_W  = 2;
  localparam int ROW_W        = 15;

  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 2'd2;

  localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RST  = 11'd640;
  localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST = 14'd480;
  localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = 12'd644;

  typedef logic [23:0] pixel_t;
  typedef logic [WIN_SIZE-1:0][7:0] lane_t;

  // applies layers first..last of the odd-even merge network, comparators past the window dropped
  // p is a power of two, so the modulo and the block compare reduce to masks
  function automatic lane_t net_layers(lane_t v, int first, int last);
    lane_t r;
    int l, p, k, j, i, lo, hi;
    logic [7:0] a, b;
    r = v;
    l = 0;
    for (p = 1; p < NET_SIZE; p = p * 2) begin
      for (k = p; k >= 1; k = k / 2) begin
        for (j = k & (p - 1); j <= NET_SIZE - 1 - k; j = j + 2 * k) begin
          for (i = 0; i < k; i++) begin
            lo = i + j;
            hi = i + j + k;
            if (l >= first && l <= last && ((lo ^ hi) & ~(2 * p - 1)) == 0
                && hi < WIN_SIZE) begin
              a = r[hi];
              b = r[lo];
              r[hi] = (a > b) ? a : b;
              r[lo] = (a < b) ? a : b;
            end
          end
        end
        l = l + 1;
      end
    end
    return r;
  endfunction

endpackage

### design/rgb_median_filter_5x5_unit.sv
// top level of the rgb 5x5 median filter: line store, window and pipelined sorting network
//
// usage:
//   s_* carries source pixels of a border-extended image in raster order, one word per
//   pixel, rows src_width wide and out_height+4 rows tall. m_* carries one median pixel
//   per output position, m_tlast marks the last word of a frame. cfg_we/cfg_index/cfg_data
//   write out_width (0), out_height (1) and src_width (2); write only while idle.
//   throughput: one pixel per clock while the output is not stalled, set by the single-port
//   line store that is read at acceptance and written back from the p1 stage at a different column.
//   pipeline: line store read at acceptance, window update, 5 sorting stages of 3
//   comparator layers each.
//   reset: counters, window and all pipeline valids clear, registers go to 640/480/644;
//   the line store holds garbage until rows are written, which a valid frame never reads.
//   stall: when m_tready is low with a word pending, the whole pipeline holds and
//   s_tready drops; a pending word never blocks acceptance otherwise.
module rgb_median_filter_5x5_unit
  import rgbmf5_pkg::*;
#(
  parameter int MAX_SRC_WIDTH = MAX_SRC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // red_median [7:0], green_median [15:8], blue_median [23:16]
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW   = $clog2(MAX_SRC_WIDTH);
  localparam int CMPW = (CW + 2 > ROW_W) ? CW + 2 : ROW_W;
  localparam int NS   = NUM_SORT_STAGES;

  // configuration
  logic [OUT_WIDTH_W-1:0]  out_width;
  logic [OUT_HEIGHT_W-1:0] out_height;
  logic [SRC_WIDTH_W-1:0]  src_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= OUT_WIDTH_RST;
      out_height <= OUT_HEIGHT_RST;
      src_width  <= SRC_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_WIDTH:  out_width  <= cfg_data[OUT_WIDTH_W-1:0];
        CFG_OUT_HEIGHT: out_height <= cfg_data[OUT_HEIGHT_W-1:0];
        CFG_SRC_WIDTH:  src_width  <= cfg_data[SRC_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves together unless the output word is stuck
  logic adv, accept;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  // position counters and clamped geometry
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [CMPW-1:0]  sw, ow, col_w, row_w, rows;
  logic             emit, last;

  always_comb begin
    sw = CMPW'(src_width);
    if (sw < CMPW'(WIN_DIM)) sw = CMPW'(WIN_DIM);
    if (sw > CMPW'(MAX_SRC_WIDTH)) sw = CMPW'(MAX_SRC_WIDTH);
    ow = CMPW'(out_width);
    if (ow > sw - CMPW'(4)) ow = sw - CMPW'(4);
    col_w = CMPW'(col);
    row_w = CMPW'(row);
    rows  = CMPW'(out_height) + CMPW'(4);
    emit  = (row_w >= CMPW'(4)) && (col_w >= CMPW'(4)) && (col_w <= ow + CMPW'(3))
            && (ow != '0);
    last  = (row_w == CMPW'(out_height) + CMPW'(3)) && (col_w == ow + CMPW'(3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_w + CMPW'(1) >= sw) begin
        col <= '0;
        row <= (row_w + CMPW'(1) >= rows) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line store: four previous rows per column, oldest row in the low pixel
  logic [4*24-1:0] line_mem [MAX_SRC_WIDTH];
  logic [4*24-1:0] line_rd;
  logic            p1_valid, p1_emit, p1_last;
  logic [CW-1:0]   p1_col;
  pixel_t          p1_px;

  always_ff @(posedge clk) begin
    if (adv) line_rd <= line_mem[col];
    if (adv && p1_valid) line_mem[p1_col] <= {p1_px, line_rd[4*24-1:24]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_emit <= emit;
      p1_last <= last;
      p1_col  <= col;
      p1_px   <= s_tdata;
    end
  end

  // 5x5 window, row-major, oldest column at the left
  pixel_t win [WIN_SIZE];
  logic   pw_valid, pw_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < WIN_SIZE; n++) win[n] <= '0;
      pw_valid <= 1'b0;
    end else if (adv) begin
      pw_valid <= p1_valid && p1_emit;
      if (p1_valid) begin
        for (int dy = 0; dy < WIN_DIM; dy++) begin
          for (int dx = 0; dx < WIN_DIM - 1; dx++)
            win[dy*WIN_DIM+dx] <= win[dy*WIN_DIM+dx+1];
        end
        for (int dy = 0; dy < WIN_DIM - 1; dy++)
          win[dy*WIN_DIM+WIN_DIM-1] <= line_rd[dy*24 +: 24];
        win[WIN_SIZE-1] <= p1_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pw_last <= p1_last;
  end

  // sorting pipeline, three layers per stage, one lane per channel
  lane_t win_lane [3];
  lane_t sv [NS][3];
  logic  sv_valid [NS];
  logic  sv_last  [NS];

  always_comb begin
    for (int ch = 0; ch < 3; ch++)
      for (int n = 0; n < WIN_SIZE; n++)
        win_lane[ch][n] = win[n][ch*8 +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) sv_valid[s] <= 1'b0;
    end else if (adv) begin
      sv_valid[0] <= pw_valid;
      for (int s = 1; s < NS; s++) sv_valid[s] <= sv_valid[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_last[0] <= pw_last;
      for (int ch = 0; ch < 3; ch++)
        sv[0][ch] <= net_layers(win_lane[ch], 0, LAYERS_PER_STAGE - 1);
      for (int s = 1; s < NS; s++) begin
        sv_last[s] <= sv_last[s-1];
        for (int ch = 0; ch < 3; ch++)
          sv[s][ch] <= net_layers(sv[s-1][ch], s * LAYERS_PER_STAGE,
                                  s * LAYERS_PER_STAGE + LAYERS_PER_STAGE - 1);
      end
    end
  end

  assign m_tvalid = sv_valid[NS-1];
  assign m_tlast  = sv_last[NS-1];
  assign m_tdata  = {sv[NS-1][2][MEDIAN_RANK], sv[NS-1][1][MEDIAN_RANK],
                     sv[NS-1][0][MEDIAN_RANK]};

  // the write-back column never collides with the column being read
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    accept && p1_valid |-> col != p1_col)
    else $error("line store read and write hit the same column");

  // a held output freezes the sorting pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(sv_valid[0]))
    else $error("pipeline moved during a stall");

  // a result only leaves the window stage if it came from an accepted pixel
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    adv && !p1_valid |=> !pw_valid)
    else $error("window stage valid without a source pixel");

endmodule

### verif/rgb_median_filter_5x5_unit_tb.sv
// self-checking testbench of the rgb 5x5 median filter unit
`timescale 1ns / 1ps

module rgb_median_filter_5x5_unit_tb;
  import rgbmf5_pkg::*;

  // one median word as it should leave the block
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } median_word_t;

  // wait after the last expected word before a register write or the end
  localparam int DRAIN_CYCLES = 20;
  // cycles with no word moving on either side before the run is called hung
  localparam int HANG_LIMIT   = 5000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [23:0]            s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;        // red_median [7:0], green_median [15:8], blue_median [23:16]
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_OUT_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  rgb_median_filter_5x5_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // pixels waiting to be driven and medians waiting to come out
  logic [23:0]  pixel_q[$];
  median_word_t median_q[$];
  int           errors = 0;
  int           queued = 0;
  int           sender_idle_pct = 0;
  int           receiver_idle_pct = 0;

  // shadow of the block: registers, line store, window and position
  logic [10:0] shadow_out_width  = OUT_WIDTH_RST;
  logic [13:0] shadow_out_height = OUT_HEIGHT_RST;
  logic [11:0] shadow_src_width  = SRC_WIDTH_RST;
  logic [23:0] rows_above[MAX_SRC_WIDTH_DEF][4];   // pixels kept as {red, green, blue}
  logic [23:0] window[25];
  int          col_pos = 0;
  int          row_pos = 0;

  function automatic int eff_src_width();
    int sw;
    sw = shadow_src_width;
    if (sw < 5) sw = 5;
    if (sw > MAX_SRC_WIDTH_DEF) sw = MAX_SRC_WIDTH_DEF;
    return sw;
  endfunction

  function automatic int eff_out_width();
    int ow;
    ow = shadow_out_width;
    if (ow > eff_src_width() - 4) ow = eff_src_width() - 4;
    return ow;
  endfunction

  // pruned 32-input odd-even merge sort; lanes 25..31 never take part
  function automatic logic [7:0] rank_twelve(logic [7:0] v[32]);
    int p, k, j, i, lo, hi;
    logic [7:0] a, b;
    for (p = 1; p < 32; p = p * 2)
      for (k = p; k >= 1; k = k / 2)
        for (j = k % p; j <= 31 - k; j = j + 2 * k)
          for (i = 0; i < k; i++) begin
            lo = i + j;
            hi = i + j + k;
            if (lo / (2 * p) == hi / (2 * p) && hi < 25) begin
              a = v[hi];
              b = v[lo];
              v[hi] = (a > b) ? a : b;
              v[lo] = (a < b) ? a : b;
            end
          end
    return v[12];
  endfunction

  // advances the shadow by one accepted source pixel, queues the median if one is due
  function automatic void filter_pixel(logic [23:0] word);
    logic [23:0] column[5];
    logic [7:0]  lane[32];
    logic [23:0] px;
    median_word_t m;
    int sw, ow, idx, dy, dx, ch, n;
    sw = eff_src_width();
    ow = eff_out_width();
    px = {word[7:0], word[15:8], word[23:16]};
    idx = (col_pos < MAX_SRC_WIDTH_DEF) ? col_pos : MAX_SRC_WIDTH_DEF - 1;
    for (dy = 0; dy < 4; dy++) column[dy] = rows_above[idx][dy];
    column[4] = px;
    for (dy = 0; dy < 4; dy++) rows_above[idx][dy] = column[dy + 1];
    for (dy = 0; dy < 5; dy++) begin
      for (dx = 0; dx < 4; dx++) window[dy * 5 + dx] = window[dy * 5 + dx + 1];
      window[dy * 5 + 4] = column[dy];
    end
    if (row_pos >= 4 && col_pos >= 4 && col_pos <= ow + 3 && ow > 0) begin
      for (ch = 0; ch < 3; ch++) begin
        for (n = 0; n < 32; n++)
          lane[n] = (n < 25) ? window[n][23 - 8 * ch -: 8] : 8'd0;
        case (ch)
          0: m.red = rank_twelve(lane);
          1: m.green = rank_twelve(lane);
          default: m.blue = rank_twelve(lane);
        endcase
      end
      m.last = (row_pos == int'(shadow_out_height) + 3 && col_pos == ow + 3);
      median_q.push_back(m);
    end
    if (col_pos + 1 >= sw) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= int'(shadow_out_height) + 4) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // source side: feeds pixels from the queue and predicts each accepted word
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) filter_pixel(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: random back-pressure and compare against the oldest prediction
  always @(posedge clk) begin
    median_word_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      if (m_tvalid && m_tready) begin
        if (median_q.size() == 0) begin
          $error("unexpected median word %h last %0b", m_tdata, m_tlast);
          errors++;
        end else begin
          e = median_q.pop_front();
          if (m_tdata[7:0] !== e.red) begin
            $error("red_median: expected %0d, got %0d", e.red, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== e.green) begin
            $error("green_median: expected %0d, got %0d", e.green, m_tdata[15:8]);
            errors++;
          end
          if (m_tdata[23:16] !== e.blue) begin
            $error("blue_median: expected %0d, got %0d", e.blue, m_tdata[23:16]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("frame_last: expected %0d, got %0d", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  // hang detection: no word moving on either side for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_OUT_WIDTH:  shadow_out_width = value[10:0];
      CFG_OUT_HEIGHT: shadow_out_height = value[13:0];
      CFG_SRC_WIDTH:  shadow_src_width = value[11:0];
      default: ;
    endcase
  endtask

  // waits until every pixel is in and every median out, then lets the pipe empty
  task automatic drain();
    while (pixel_q.size() > 0 || s_tvalid || median_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one channel byte: full range, extremes and single-bit patterns, or a narrow range
  // that makes many ties in the window
  function automatic logic [7:0] pick_byte(int style);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 5))
          0: return 8'h00;
          1: return 8'hff;
          2: return 8'h55;
          3: return 8'haa;
          4: return 8'h01 << $urandom_range(0, 7);
          default: return ~(8'h01 << $urandom_range(0, 7));
        endcase
      end
      default: return 8'($urandom_range(120, 123));
    endcase
  endfunction

  // queues whole frames for the current register values, so each phase ends at row 0
  task automatic queue_frames(int frames, int style);
    int f, n, total;
    total = eff_src_width() * (int'(shadow_out_height) + 4);
    for (f = 0; f < frames; f++)
      for (n = 0; n < total; n++) begin
        pixel_q.push_back({pick_byte(style), pick_byte(style), pick_byte(style)});
        queued++;
      end
  endtask

  task automatic run_phase(int ow, int oh, int sw, int frames, int style);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    write_reg(CFG_SRC_WIDTH, sw);
    queue_frames(frames, style);
    drain();
  endtask

  initial begin
    int ow, sw, oh;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 19;
    receiver_idle_pct = 78;

    // smallest frame: one median from 25 pixels of extreme bytes, flagged last
    run_phase(1, 1, 5, 1, 1);
    // top of out_height written while idle, then replaced before any pixel
    write_reg(CFG_OUT_HEIGHT, 16383);
    // output width beyond the source row: clipped to src_width - 4
    run_phase(2047, 2, 9, 1, 0);
    // source width below the floor and zero output width: only counters move
    run_phase(0, 1, 0, 1, 0);
    // zero output height: four-row frames with no medians at all
    run_phase(3, 0, 7, 2, 0);
    // many ties in every window
    run_phase(4, 3, 8, 1, 2);

    while (queued < 650) begin
      if (queued >= 430) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end else if (queued >= 220) begin
        sender_idle_pct = 78;
        receiver_idle_pct = 19;
      end
      ow = $urandom_range(1, 8);
      sw = ow + 4 + $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) sw = $urandom_range(5, ow + 3);
      oh = $urandom_range(1, 3);
      run_phase(ow, oh, sw, 1, $urandom_range(0, 3) == 0 ? 1 : 0);
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
